[rtl/core/light_grid_trilinear_sampler_defines.svh]
// Assertion macros used by the light grid sampler checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef LIGHT_GRID_TRILINEAR_SAMPLER_DEFINES_SVH
`define LIGHT_GRID_TRILINEAR_SAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define LGTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define LGTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lgts_pkg.sv]
// Shared constants and types of the light grid trilinear sampler.
// No dependencies; used by every module of the block.
`default_nettype none

package lgts_pkg;

  // Grid geometry: 64 cells per axis, index = {x, y, z}
  localparam int unsigned AXIS_BITS = 6;
  localparam int unsigned IDX_BITS  = 3 * AXIS_BITS;
  localparam int unsigned CELLS     = 1 << IDX_BITS;
  localparam logic [AXIS_BITS-1:0] AXIS_TOP  = {AXIS_BITS{1'b1}};
  localparam logic [AXIS_BITS-1:0] AXIS_LAST = AXIS_TOP - 1'b1;

  // Fixed-point formats
  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned FRAC_BITS  = 10;
  localparam int unsigned WGT_BITS   = FRAC_BITS + 1;
  localparam int unsigned CW_BITS    = 3 * FRAC_BITS + 1;   // corner weight, max 2^30
  localparam int unsigned CHAN_BITS  = 8;
  localparam int unsigned SUM_BITS   = CW_BITS + CHAN_BITS - 1;
  localparam int unsigned LIGHT_BITS = 15;
  localparam logic [WGT_BITS-1:0] WGT_ONE = WGT_BITS'(1 << FRAC_BITS);

  // floor(r / 255) = (r * RECIP_255) >> RECIP_SHIFT, exact for r < 2^22
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [22:0] RECIP_255   = 23'd4210753;

  // Queue sizes
  localparam int unsigned CMD_DEPTH   = 2;
  localparam int unsigned CMD_PTR     = 1;
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_PTR     = 2;
  localparam int unsigned CREDIT_BITS = 3;

  // Item codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Classified item, front to engine
  typedef struct packed {
    logic                    mode;
    logic [IDX_BITS-1:0]     cell_index;
    logic [CHAN_BITS-1:0]    red;
    logic [CHAN_BITS-1:0]    green;
    logic [CHAN_BITS-1:0]    blue;
    logic [AXIS_BITS-1:0]    base_x;
    logic [AXIS_BITS-1:0]    base_y;
    logic [AXIS_BITS-1:0]    base_z;
    logic [WGT_BITS-1:0]     frac_x;
    logic [WGT_BITS-1:0]     frac_y;
    logic [WGT_BITS-1:0]     frac_z;
  } cmd_t;

  // Finished weighted sums of one query, engine to scaler
  typedef struct packed {
    logic                valid;
    logic [SUM_BITS-1:0] sum_r;
    logic [SUM_BITS-1:0] sum_g;
    logic [SUM_BITS-1:0] sum_b;
    logic [CW_BITS-1:0]  dark;
  } acc_t;

  // Engine status toward the front
  typedef struct packed {
    logic clearing;
  } eng_status_t;

endpackage

`default_nettype wire

[rtl/core/light_grid_trilinear_sampler.sv]
// Light grid trilinear sampler: a 64^3 grid of RGB byte cells with write and
// trilinear query items. Each side is a queue:
//   input  - push / full; an item is taken at a clock edge with push high and
//            full low. mode 0 writes one cell, mode 1 queries at pos_x/y/z
//            (signed, 3 fraction bits).
//   result - empty / pop; the oldest result sits on light_red/green/blue
//            (12 fraction bits) while empty is low and leaves on pop.
// A write gives no result and uses the grid memory port once. A query reads
// its eight corner cells from the single-ported grid memory, one per cycle,
// so a new query starts only after the last corner of the one before; its
// result passes the engine and scaler stages. Results come out in query order.
// After reset the whole grid is cleared to zero, one cell per cycle, with full
// held high throughout. Four results may wait in the result queue; when it is
// taken slowly, queries stop starting and the two-entry input queue fills,
// then full rises. Writes keep flowing until a query blocks the head.
// Depends on lgts_pkg, lgts_front, lgts_engine and lgts_scale.
`default_nettype none

module light_grid_trilinear_sampler (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic                                  mode_i,
  input  wire logic [lgts_pkg::IDX_BITS-1:0]         cell_index_i,
  input  wire logic [lgts_pkg::CHAN_BITS-1:0]        cell_red_i,
  input  wire logic [lgts_pkg::CHAN_BITS-1:0]        cell_green_i,
  input  wire logic [lgts_pkg::CHAN_BITS-1:0]        cell_blue_i,
  input  wire logic signed [lgts_pkg::POS_BITS-1:0]  pos_x_i,
  input  wire logic signed [lgts_pkg::POS_BITS-1:0]  pos_y_i,
  input  wire logic signed [lgts_pkg::POS_BITS-1:0]  pos_z_i,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic [lgts_pkg::LIGHT_BITS-1:0]            light_red_o,
  output logic [lgts_pkg::LIGHT_BITS-1:0]            light_green_o,
  output logic [lgts_pkg::LIGHT_BITS-1:0]            light_blue_o
);

  lgts_pkg::eng_status_t status;
  lgts_pkg::cmd_t        cmd;
  lgts_pkg::acc_t        acc;
  logic                  cmd_valid;
  logic                  cmd_pop;
  logic                  res_pop;

  // Front: accept, locate, command queue
  lgts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .status_i     (status),
    .push         (push),
    .full         (full),
    .mode_i       (mode_i),
    .cell_index_i (cell_index_i),
    .cell_red_i   (cell_red_i),
    .cell_green_i (cell_green_i),
    .cell_blue_i  (cell_blue_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // Engine: grid memory and corner accumulation
  lgts_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_pop_i   (res_pop),
    .status_o    (status),
    .acc_o       (acc)
  );

  // Scaling and result queue
  lgts_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .empty         (empty),
    .pop           (pop),
    .pop_acc_o     (res_pop),
    .light_red_o   (light_red_o),
    .light_green_o (light_green_o),
    .light_blue_o  (light_blue_o)
  );

endmodule

`default_nettype wire

[rtl/core/lgts_front.sv]
// Front end: accepts items, turns query positions into base cell and weight
// fraction per axis, and holds them in a two-entry command queue. Uses lgts_pkg.
`default_nettype none

module lgts_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lgts_pkg::eng_status_t           status_i,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            mode_i,
  input  wire logic [lgts_pkg::IDX_BITS-1:0]   cell_index_i,
  input  wire logic [lgts_pkg::CHAN_BITS-1:0]  cell_red_i,
  input  wire logic [lgts_pkg::CHAN_BITS-1:0]  cell_green_i,
  input  wire logic [lgts_pkg::CHAN_BITS-1:0]  cell_blue_i,
  input  wire logic signed [lgts_pkg::POS_BITS-1:0] pos_x_i,
  input  wire logic signed [lgts_pkg::POS_BITS-1:0] pos_y_i,
  input  wire logic signed [lgts_pkg::POS_BITS-1:0] pos_z_i,
  output logic                                 cmd_valid_o,
  output lgts_pkg::cmd_t                       cmd_o,
  input  wire logic                            cmd_pop_i
);

  localparam int unsigned LOC_BITS = lgts_pkg::AXIS_BITS + lgts_pkg::WGT_BITS;
  localparam int unsigned CNT_BITS = lgts_pkg::CMD_PTR + 1;

  // Offset by 4096 units (flip sign bit), split into base cell and fraction;
  // clamp to the far face when the base lands on the last cell
  function automatic logic [LOC_BITS-1:0] locate(logic [lgts_pkg::POS_BITS-1:0] pos);
    logic [lgts_pkg::POS_BITS-1:0]  u;
    logic [lgts_pkg::AXIS_BITS-1:0] base;
    u    = {~pos[lgts_pkg::POS_BITS-1], pos[lgts_pkg::POS_BITS-2:0]};
    base = u[lgts_pkg::POS_BITS-1 -: lgts_pkg::AXIS_BITS];
    if (base == lgts_pkg::AXIS_TOP) begin
      return {lgts_pkg::AXIS_LAST, lgts_pkg::WGT_ONE};
    end
    return {base, 1'b0, u[lgts_pkg::FRAC_BITS-1:0]};
  endfunction

  lgts_pkg::cmd_t             cmd_mem_q [lgts_pkg::CMD_DEPTH];
  lgts_pkg::cmd_t             cmd_new;
  logic [lgts_pkg::CMD_PTR-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0]        cnt_q, cnt_d;
  logic                       q_full;
  logic                       accept;
  logic                       pop_acc;

  // Classify and locate the incoming item
  always_comb begin
    cmd_new.mode       = mode_i;
    cmd_new.cell_index = cell_index_i;
    cmd_new.red        = cell_red_i;
    cmd_new.green      = cell_green_i;
    cmd_new.blue       = cell_blue_i;
    {cmd_new.base_x, cmd_new.frac_x} = locate(pos_x_i);
    {cmd_new.base_y, cmd_new.frac_y} = locate(pos_y_i);
    {cmd_new.base_z, cmd_new.frac_z} = locate(pos_z_i);
  end

  // Queue handshake; nothing is taken while the grid is being cleared
  assign q_full      = (cnt_q == CNT_BITS'(lgts_pkg::CMD_DEPTH));
  assign full        = q_full | status_i.clearing;
  assign accept      = push & ~full;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop_acc     = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = cmd_mem_q[rd_ptr_q];
  assign cnt_d       = cnt_q + CNT_BITS'(accept) - CNT_BITS'(pop_acc);

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_acc) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lgts_engine.sv]
// Back end: grid memory with its clearing pass, corner sequencer and the
// weight / accumulate pipeline. Uses lgts_pkg.
`default_nettype none

module lgts_engine (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cmd_valid_i,
  input  wire lgts_pkg::cmd_t        cmd_i,
  output logic                       cmd_pop_o,
  input  wire logic                  res_pop_i,
  output lgts_pkg::eng_status_t      status_o,
  output lgts_pkg::acc_t             acc_o
);

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  localparam int unsigned IB = lgts_pkg::IDX_BITS;
  localparam int unsigned AB = lgts_pkg::AXIS_BITS;
  localparam int unsigned WB = lgts_pkg::WGT_BITS;
  localparam int unsigned CB = lgts_pkg::CHAN_BITS;
  localparam int unsigned PB = 2 * WB;
  localparam int unsigned SB = lgts_pkg::SUM_BITS;
  localparam int unsigned DB = lgts_pkg::CW_BITS;

  logic                 state_q, state_d;
  logic [IB-1:0]        clr_addr_q;
  logic [2:0]           corner_q;
  logic [lgts_pkg::CREDIT_BITS-1:0] credit_q, credit_d;

  logic                 is_write, credit_ok, issue, wr, start;
  logic                 dx, dy, dz;
  logic [AB-1:0]        ax, ay, az;
  logic [WB-1:0]        wx, wy, wz;

  logic                 mem_we;
  logic [IB-1:0]        mem_addr;
  logic [3*CB-1:0]      mem_wdata;
  logic [3*CB-1:0]      grid_mem [lgts_pkg::CELLS];
  logic [3*CB-1:0]      rd_q;

  // pipeline stages
  logic                 s1_vld_q, s1_first_q, s1_last_q;
  logic [PB-1:0]        s1_wxy_q;
  logic [WB-1:0]        s1_wz_q;
  logic                 s2_vld_q, s2_first_q, s2_last_q;
  logic [DB-1:0]        s2_w_q;
  logic [3*CB-1:0]      s2_rgb_q;
  logic [PB+WB-1:0]     w_full;
  logic                 s3_vld_q, s3_first_q, s3_last_q;
  logic [SB-1:0]        s3_prod_q [3];
  logic [DB-1:0]        s3_dark_q;
  logic [DB+CB-1:0]     prod_full [3];
  logic [SB-1:0]        acc_q [3];
  logic [SB-1:0]        sum_d [3];
  logic [DB-1:0]        dacc_q, dsum_d;
  logic                 acc_vld_q;
  logic [SB-1:0]        acc_out_q [3];
  logic [DB-1:0]        dark_out_q;

  // Head item classification and issue conditions
  assign is_write  = (cmd_i.mode == lgts_pkg::MODE_WRITE);
  assign credit_ok = (credit_q < lgts_pkg::CREDIT_BITS'(lgts_pkg::OUT_DEPTH));
  assign wr        = (state_q == ST_RUN) & cmd_valid_i & is_write;
  assign issue     = (state_q == ST_RUN) & cmd_valid_i & ~is_write &
                     ((corner_q != 3'd0) | credit_ok);
  assign start     = issue & (corner_q == 3'd0);
  assign cmd_pop_o = wr | (issue & (corner_q == 3'd7));
  assign status_o.clearing = (state_q == ST_CLEAR);

  // Corner address and axis weights
  assign dx = corner_q[2];
  assign dy = corner_q[1];
  assign dz = corner_q[0];
  assign ax = cmd_i.base_x + AB'(dx);
  assign ay = cmd_i.base_y + AB'(dy);
  assign az = cmd_i.base_z + AB'(dz);
  assign wx = dx ? cmd_i.frac_x : lgts_pkg::WGT_ONE - cmd_i.frac_x;
  assign wy = dy ? cmd_i.frac_y : lgts_pkg::WGT_ONE - cmd_i.frac_y;
  assign wz = dz ? cmd_i.frac_z : lgts_pkg::WGT_ONE - cmd_i.frac_z;

  // Memory port select: clearing pass, cell write, or corner read
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {ax, ay, az};
    mem_wdata = {cmd_i.red, cmd_i.green, cmd_i.blue};
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_addr_q;
      mem_wdata = '0;
    end else if (wr) begin
      mem_we   = 1'b1;
      mem_addr = cmd_i.cell_index;
    end
  end

  // Grid memory, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= mem_wdata;
    end
    rd_q <= grid_mem[mem_addr];
  end

  // Sequencer next state and result credit
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_addr_q == {IB{1'b1}}) state_d = ST_RUN;
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_CLEAR;
    endcase
    credit_d = credit_q + lgts_pkg::CREDIT_BITS'(start)
                        - lgts_pkg::CREDIT_BITS'(res_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      corner_q   <= '0;
      credit_q   <= '0;
    end else begin
      state_q  <= state_d;
      credit_q <= credit_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (issue) begin
        corner_q <= corner_q + 1'b1;
      end
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      acc_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= issue;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      acc_vld_q <= s3_vld_q & s3_last_q;
    end
  end

  // Weight products and per-corner terms
  assign w_full = (PB+WB)'(s1_wxy_q) * (PB+WB)'(s1_wz_q);

  always_comb begin
    prod_full[0] = (DB+CB)'(s2_w_q) * (DB+CB)'(s2_rgb_q[3*CB-1 -: CB]);
    prod_full[1] = (DB+CB)'(s2_w_q) * (DB+CB)'(s2_rgb_q[2*CB-1 -: CB]);
    prod_full[2] = (DB+CB)'(s2_w_q) * (DB+CB)'(s2_rgb_q[CB-1:0]);
  end

  always_ff @(posedge clk_i) begin
    // stage 1: wx*wy, read issued
    s1_first_q <= (corner_q == 3'd0);
    s1_last_q  <= (corner_q == 3'd7);
    s1_wxy_q   <= PB'(wx) * PB'(wy);
    s1_wz_q    <= wz;
    // stage 2: full corner weight, cell bytes
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_w_q     <= w_full[DB-1:0];
    s2_rgb_q   <= rd_q;
    // stage 3: weighted bytes; dark corner when any channel is zero
    s3_first_q <= s2_first_q;
    s3_last_q  <= s2_last_q;
    for (int c = 0; c < 3; c++) begin
      s3_prod_q[c] <= prod_full[c][SB-1:0];
    end
    s3_dark_q  <= ((s2_rgb_q[3*CB-1 -: CB] == '0) || (s2_rgb_q[2*CB-1 -: CB] == '0) ||
                   (s2_rgb_q[CB-1:0] == '0)) ? s2_w_q : '0;
  end

  // Stage 4: accumulate the eight corners
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = (s3_first_q ? '0 : acc_q[c]) + s3_prod_q[c];
    end
    dsum_d = (s3_first_q ? '0 : dacc_q) + s3_dark_q;
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= sum_d[c];
      end
      dacc_q <= dsum_d;
    end
    for (int c = 0; c < 3; c++) begin
      acc_out_q[c] <= sum_d[c];
    end
    dark_out_q <= dsum_d;
  end

  assign acc_o = '{valid: acc_vld_q, sum_r: acc_out_q[0], sum_g: acc_out_q[1],
                   sum_b: acc_out_q[2], dark: dark_out_q};

endmodule

`default_nettype wire

[rtl/core/lgts_scale.sv]
// Result side: brightness scaling by (8 - dark) / 510 in three stages and the
// four-entry result queue. Uses lgts_pkg.
`default_nettype none

module lgts_scale (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lgts_pkg::acc_t                   acc_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic                                  pop_acc_o,
  output logic [lgts_pkg::LIGHT_BITS-1:0]       light_red_o,
  output logic [lgts_pkg::LIGHT_BITS-1:0]       light_green_o,
  output logic [lgts_pkg::LIGHT_BITS-1:0]       light_blue_o
);

  localparam int unsigned SB  = lgts_pkg::SUM_BITS;
  localparam int unsigned DB  = lgts_pkg::CW_BITS;
  localparam int unsigned XB  = SB - lgts_pkg::FRAC_BITS;   // color, 20 fraction bits
  localparam int unsigned HB  = DB + 3;                     // 8 * 2^30 needs 3*FRAC+4 bits
  localparam int unsigned PRB = XB + DB;
  localparam int unsigned TB  = XB + HB - 1;                // cx * 2^33
  localparam int unsigned QSH = 3 * lgts_pkg::FRAC_BITS + 8; // divide by 2^38
  localparam int unsigned RB  = TB - QSH - 1;               // after extra halving
  localparam int unsigned MB  = RB + 23;
  localparam int unsigned LB  = lgts_pkg::LIGHT_BITS;
  localparam int unsigned CNT_BITS = lgts_pkg::OUT_PTR + 1;

  typedef struct packed {
    logic [LB-1:0] red;
    logic [LB-1:0] green;
    logic [LB-1:0] blue;
  } res_t;

  logic                a_vld_q, b_vld_q;
  logic [XB-1:0]       cx_q [3];
  logic [PRB-1:0]      p_q [3];
  logic [XB-1:0]       cx_d [3];
  logic [TB-1:0]       x_d [3];
  logic [RB-1:0]       r_q [3];
  logic [MB-1:0]       m_d [3];
  res_t                res_new;
  res_t                res_mem_q [lgts_pkg::OUT_DEPTH];
  logic [lgts_pkg::OUT_PTR-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] cnt_q;

  // Stage A: color with 20 fraction bits times dark weight
  assign cx_d[0] = acc_i.sum_r[SB-1:lgts_pkg::FRAC_BITS];
  assign cx_d[1] = acc_i.sum_g[SB-1:lgts_pkg::FRAC_BITS];
  assign cx_d[2] = acc_i.sum_b[SB-1:lgts_pkg::FRAC_BITS];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      cx_q[c] <= cx_d[c];
      p_q[c]  <= PRB'(cx_d[c]) * PRB'(acc_i.dark);
    end
  end

  // Stage B: cx * (8*2^30 - dark) = cx*2^33 - cx*dark, then / 2^38 / 2
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      x_d[c] = {cx_q[c], {(HB-1){1'b0}}} - TB'(p_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      r_q[c] <= x_d[c][TB-1:QSH+1];
    end
  end

  // Stage C: divide by 255 through the reciprocal
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      m_d[c] = MB'(r_q[c]) * MB'(lgts_pkg::RECIP_255);
    end
    res_new.red   = m_d[0][lgts_pkg::RECIP_SHIFT +: LB];
    res_new.green = m_d[1][lgts_pkg::RECIP_SHIFT +: LB];
    res_new.blue  = m_d[2][lgts_pkg::RECIP_SHIFT +: LB];
  end

  // Stage valid flags and queue pointers
  assign empty     = (cnt_q == '0);
  assign pop_acc_o = pop & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      a_vld_q <= acc_i.valid;
      b_vld_q <= a_vld_q;
      if (b_vld_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_acc_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_BITS'(b_vld_q) - CNT_BITS'(pop_acc_o);
    end
  end

  // Result queue storage; room is reserved by the engine before a query starts
  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      res_mem_q[wr_ptr_q] <= res_new;
    end
  end

  assign light_red_o   = res_mem_q[rd_ptr_q].red;
  assign light_green_o = res_mem_q[rd_ptr_q].green;
  assign light_blue_o  = res_mem_q[rd_ptr_q].blue;

endmodule

`default_nettype wire

[rtl/core/lgts_checker.sv]
// Port-level checks for the light grid sampler, bound to the top level.
// Uses the macros of light_grid_trilinear_sampler_defines.svh and lgts_pkg.
`default_nettype none
`include "light_grid_trilinear_sampler_defines.svh"

module lgts_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  full,
  input wire logic                                  empty,
  input wire logic                                  pop,
  input wire logic [lgts_pkg::LIGHT_BITS-1:0]       light_red_o,
  input wire logic [lgts_pkg::LIGHT_BITS-1:0]       light_green_o,
  input wire logic [lgts_pkg::LIGHT_BITS-1:0]       light_blue_o
);

  localparam logic [lgts_pkg::LIGHT_BITS-1:0] LIGHT_MAX = 15'd16384;

  // A waiting result that is not taken stays put
  `LGTS_ASSERT_NXT(a_res_hold, !empty && !pop, !empty && $stable(light_red_o) && $stable(light_green_o) && $stable(light_blue_o), "result changed while stalled")

  // Scaled color never exceeds 4.0
  `LGTS_ASSERT_IMP(a_res_range, !empty, light_red_o <= LIGHT_MAX && light_green_o <= LIGHT_MAX && light_blue_o <= LIGHT_MAX, "result above 4.0")

  // The grid clearing pass holds off input right after reset
  `LGTS_ASSERT_IMP(a_clear_full, !$past(rst_ni), full && empty, "input open during grid clear")

endmodule

bind light_grid_trilinear_sampler lgts_checker u_lgts_checker (.*);

`default_nettype wire

[verif/tb_light_grid_trilinear_sampler.sv]
// Testbench for light_grid_trilinear_sampler: grid writes and trilinear queries
// driven through the push/full queue, results popped and checked item by item.
// Depends on lgts_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 100ps

module tb_light_grid_trilinear_sampler;
  import lgts_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 500;
  localparam int unsigned WATCHDOG_LIMIT = 800000;  // longer than the grid clear
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned MAX_PRINTS     = 50;

  // One input item as seen on the ports
  typedef struct {
    logic                       mode;
    logic [IDX_BITS-1:0]        idx;
    logic [CHAN_BITS-1:0]       red;
    logic [CHAN_BITS-1:0]       green;
    logic [CHAN_BITS-1:0]       blue;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
    logic signed [POS_BITS-1:0] pos_z;
  } grid_item_t;

  // One light result
  typedef struct {
    logic [LIGHT_BITS-1:0] red;
    logic [LIGHT_BITS-1:0] green;
    logic [LIGHT_BITS-1:0] blue;
  } light_rgb_t;

  // Keeps a shadow of the grid and the queue of predicted light values
  class light_scoreboard;
    bit [3*CHAN_BITS-1:0] cells [CELLS];
    light_rgb_t           expected_light_q [$];
    int                   errors;

    function int pending();
      return expected_light_q.size();
    endfunction

    // World position to base cell and 10-bit fraction, saturated at the far face
    function void axis_locate(input logic signed [POS_BITS-1:0] p,
                              output bit [AXIS_BITS-1:0] base,
                              output bit [WGT_BITS-1:0] frac);
      bit [POS_BITS-1:0] u;
      u = {~p[POS_BITS-1], p[POS_BITS-2:0]};  // p + 4096*8
      if (u[POS_BITS-1 -: AXIS_BITS] == AXIS_TOP) begin
        base = AXIS_LAST;
        frac = WGT_ONE;
      end else begin
        base = u[POS_BITS-1 -: AXIS_BITS];
        frac = {1'b0, u[FRAC_BITS-1:0]};
      end
    endfunction

    function light_rgb_t predict_light(grid_item_t it);
      bit [AXIS_BITS-1:0]   bx, by, bz;
      bit [WGT_BITS-1:0]    fx, fy, fz;
      longint unsigned      csum [3];
      longint unsigned      dark, wx, wy, wz, w, s, den;
      bit [3*CHAN_BITS-1:0] cval;
      bit [IDX_BITS-1:0]    idx;
      light_rgb_t           res;
      axis_locate(it.pos_x, bx, fx);
      axis_locate(it.pos_y, by, fy);
      axis_locate(it.pos_z, bz, fz);
      csum = '{0, 0, 0};
      dark = 0;
      // corner k: bit 2 = x+1, bit 1 = y+1, bit 0 = z+1
      for (int k = 0; k < 8; k++) begin
        wx = k[2] ? fx : WGT_ONE - fx;
        wy = k[1] ? fy : WGT_ONE - fy;
        wz = k[0] ? fz : WGT_ONE - fz;
        w = wx * wy * wz;
        idx = {AXIS_BITS'(bx + k[2]), AXIS_BITS'(by + k[1]), AXIS_BITS'(bz + k[0])};
        cval = cells[idx];
        csum[0] += w * cval[23:16];
        csum[1] += w * cval[15:8];
        csum[2] += w * cval[7:0];
        if (cval[23:16] == 0 || cval[15:8] == 0 || cval[7:0] == 0)
          dark += w;
      end
      // scale by (8 - dark weight) / 510, colour truncated to 20 fraction bits
      s   = (64'd8 << (3 * FRAC_BITS)) - dark;
      den = 64'd510 << (3 * FRAC_BITS + 8);
      res.red   = LIGHT_BITS'(((csum[0] >> FRAC_BITS) * s) / den);
      res.green = LIGHT_BITS'(((csum[1] >> FRAC_BITS) * s) / den);
      res.blue  = LIGHT_BITS'(((csum[2] >> FRAC_BITS) * s) / den);
      return res;
    endfunction

    // Accepted input item: update the grid or queue a prediction
    function void note_item(grid_item_t it);
      if (it.mode == MODE_WRITE)
        cells[it.idx] = {it.red, it.green, it.blue};
      else
        expected_light_q.push_back(predict_light(it));
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS)
        $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Accepted result: compare with the oldest prediction
    task check_light(light_rgb_t got);
      light_rgb_t exp_l;
      if (expected_light_q.size() == 0) begin
        report($sformatf("result %0d/%0d/%0d with none expected",
                         got.red, got.green, got.blue));
        return;
      end
      exp_l = expected_light_q.pop_front();
      if (got.red !== exp_l.red)
        report($sformatf("light_red got %0d exp %0d", got.red, exp_l.red));
      if (got.green !== exp_l.green)
        report($sformatf("light_green got %0d exp %0d", got.green, exp_l.green));
      if (got.blue !== exp_l.blue)
        report($sformatf("light_blue got %0d exp %0d", got.blue, exp_l.blue));
    endtask
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic                       mode_i = MODE_WRITE;
  logic [IDX_BITS-1:0]        cell_index_i = '0;
  logic [CHAN_BITS-1:0]       cell_red_i = '0;
  logic [CHAN_BITS-1:0]       cell_green_i = '0;
  logic [CHAN_BITS-1:0]       cell_blue_i = '0;
  logic signed [POS_BITS-1:0] pos_x_i = '0;
  logic signed [POS_BITS-1:0] pos_y_i = '0;
  logic signed [POS_BITS-1:0] pos_z_i = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [LIGHT_BITS-1:0]      light_red_o;
  logic [LIGHT_BITS-1:0]      light_green_o;
  logic [LIGHT_BITS-1:0]      light_blue_o;

  light_scoreboard sb;
  int unsigned     idle_cycles = 0;
  int unsigned     sent_items = 0;
  bit              in_steady = 1'b0;

  light_grid_trilinear_sampler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .cell_index_i  (cell_index_i),
    .cell_red_i    (cell_red_i),
    .cell_green_i  (cell_green_i),
    .cell_blue_i   (cell_blue_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .empty         (empty),
    .pop           (pop),
    .light_red_o   (light_red_o),
    .light_green_o (light_green_o),
    .light_blue_o  (light_blue_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones, none in steady stretches
  function automatic int pick_gap(bit steady);
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [IDX_BITS-1:0] cell_at(int x, int y, int z);
    return {AXIS_BITS'(x), AXIS_BITS'(y), AXIS_BITS'(z)};
  endfunction

  // Grid coordinate in 1/1024 cell (offset world eighths) to signed position
  function automatic logic signed [POS_BITS-1:0] pos_of(bit [POS_BITS-1:0] u);
    return {~u[POS_BITS-1], u[POS_BITS-2:0]};
  endfunction

  // Accepted items go to the scoreboard, popped results are checked
  always @(posedge clk_i) begin
    grid_item_t seen;
    light_rgb_t got;
    if (rst_ni && push && !full) begin
      seen.mode  = mode_i;
      seen.idx   = cell_index_i;
      seen.red   = cell_red_i;
      seen.green = cell_green_i;
      seen.blue  = cell_blue_i;
      seen.pos_x = pos_x_i;
      seen.pos_y = pos_y_i;
      seen.pos_z = pos_z_i;
      sb.note_item(seen);
    end
    if (rst_ni && pop && !empty) begin
      got.red   = light_red_o;
      got.green = light_green_o;
      got.blue  = light_blue_o;
      sb.check_light(got);
    end
  end

  // Watchdog on cycles without any accepted item or result
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls, with steady stretches now and then
  initial begin
    int  g;
    bit  out_steady;
    out_steady = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0)
        out_steady = !out_steady;
      g = pick_gap(out_steady);
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
    end
  end

  // Offer one item and hold it until taken; returns at the accepting edge
  task automatic send_item(grid_item_t it);
    int g;
    g = pick_gap(in_steady);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    mode_i       <= it.mode;
    cell_index_i <= it.idx;
    cell_red_i   <= it.red;
    cell_green_i <= it.green;
    cell_blue_i  <= it.blue;
    pos_x_i      <= it.pos_x;
    pos_y_i      <= it.pos_y;
    pos_z_i      <= it.pos_z;
    push         <= 1'b1;
    do @(posedge clk_i); while (full !== 1'b0);
    sent_items++;
  endtask

  // Write item; position fields carry noise
  task automatic send_write(logic [IDX_BITS-1:0] idx, logic [CHAN_BITS-1:0] r,
                            logic [CHAN_BITS-1:0] g, logic [CHAN_BITS-1:0] b);
    grid_item_t it;
    it.mode  = MODE_WRITE;
    it.idx   = idx;
    it.red   = r;
    it.green = g;
    it.blue  = b;
    it.pos_x = POS_BITS'($urandom);
    it.pos_y = POS_BITS'($urandom);
    it.pos_z = POS_BITS'($urandom);
    send_item(it);
  endtask

  // Query item at grid coordinates; cell fields carry noise
  task automatic send_query(bit [POS_BITS-1:0] ux, bit [POS_BITS-1:0] uy,
                            bit [POS_BITS-1:0] uz);
    grid_item_t it;
    it.mode  = MODE_QUERY;
    it.idx   = IDX_BITS'($urandom);
    it.red   = CHAN_BITS'($urandom);
    it.green = CHAN_BITS'($urandom);
    it.blue  = CHAN_BITS'($urandom);
    it.pos_x = pos_of(ux);
    it.pos_y = pos_of(uy);
    it.pos_z = pos_of(uz);
    send_item(it);
  endtask

  // Stop offering items until every expected result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk_i);
  endtask

  // Base cell of a sequence: edges of the grid come up often
  function automatic bit [AXIS_BITS-1:0] pick_base();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0)
      return '0;
    if (r == 1)
      return AXIS_LAST;
    return AXIS_BITS'($urandom_range(0, AXIS_LAST));
  endfunction

  // Point inside the cell block at base, sometimes past the far face
  function automatic bit [POS_BITS-1:0] pick_coord(bit [AXIS_BITS-1:0] base);
    int r;
    if (base == AXIS_LAST && $urandom_range(0, 3) == 0)
      return {AXIS_TOP, FRAC_BITS'($urandom)};
    r = $urandom_range(0, 5);
    if (r == 0)
      return {base, {FRAC_BITS{1'b0}}};
    if (r == 1)
      return {base, {FRAC_BITS{1'b1}}};
    return {base, FRAC_BITS'($urandom)};
  endfunction

  // Stimulus
  initial begin
    bit [AXIS_BITS-1:0]  bx, by, bz;
    logic [CHAN_BITS-1:0] r, g, b;
    int                   kind, nq, c;
    bit                   broken, mid_drained;
    sb = new;
    mid_drained = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty grid at the lowest position
    send_query(16'h0000, 16'h0000, 16'h0000);
    // all-bright block at the origin gives the 4.0 maximum
    for (int k = 0; k < 8; k++)
      send_write(cell_at(k >> 2 & 1, k >> 1 & 1, k & 1), 8'hFF, 8'hFF, 8'hFF);
    send_query(16'h0000, 16'h0000, 16'h0000);
    send_query(16'h0200, 16'h0200, 16'h0200);
    // one dark corner
    send_write(cell_at(1, 1, 1), 8'h00, 8'hFF, 8'h80);
    send_query(16'h0200, 16'h0200, 16'h0200);
    send_query(16'h03FF, 16'h0000, 16'h01FF);
    // top index and the highest position, saturated onto the far face
    send_write({IDX_BITS{1'b1}}, 8'hFF, 8'hFF, 8'hFF);
    send_query(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_write(cell_at(32, 32, 32), 8'h01, 8'h02, 8'h03);
    send_query(16'h8000, 16'h8000, 16'h8000);
    // exactly on the boundary past the last base cell
    send_query(16'hFC00, 16'hFC00, 16'hFFFF);
    send_write({IDX_BITS{1'b1}}, 8'h00, 8'h80, 8'hFF);
    send_query(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_write('0, 8'h00, 8'h00, 8'h00);
    send_query(16'h0000, 16'h0000, 16'h0000);
    send_query(16'h01FF, 16'h0000, 16'h03FF);
    wait_drained();

    // Random: mostly fill-then-sample sequences, the rest noise
    while (sent_items < 25 + RANDOM_ITEMS) begin
      in_steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        bx = pick_base();
        by = pick_base();
        bz = pick_base();
        broken = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < 8; k++) begin
          r = CHAN_BITS'($urandom_range(1, 255));
          g = CHAN_BITS'($urandom_range(1, 255));
          b = CHAN_BITS'($urandom_range(1, 255));
          c = $urandom_range(0, 9);
          if (c == 0) r = '0;
          if (c == 1) g = '0;
          if (c == 2) b = '0;
          if (c == 3) begin
            r = '1;
            g = '1;
            b = '1;
          end
          if (!broken || $urandom_range(0, 1) == 1)
            send_write(cell_at(bx + (k >> 2 & 1), by + (k >> 1 & 1), bz + (k & 1)),
                       r, g, b);
        end
        nq = $urandom_range(1, 4);
        repeat (nq) send_query(pick_coord(bx), pick_coord(by), pick_coord(bz));
      end else begin
        nq = $urandom_range(1, 4);
        repeat (nq) begin
          if ($urandom_range(0, 1) == 0)
            send_write(IDX_BITS'($urandom), CHAN_BITS'($urandom),
                       CHAN_BITS'($urandom), CHAN_BITS'($urandom));
          else
            send_query(POS_BITS'($urandom), POS_BITS'($urandom), POS_BITS'($urandom));
        end
      end
      if (!mid_drained && sent_items > 25 + RANDOM_ITEMS / 2) begin
        mid_drained = 1'b1;
        wait_drained();
      end
    end

    // Wind down: everything popped, then a few more cycles for strays
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
